// File: rtl/ssi_pkg.sv
// shared types and constants for the sorted set intersection block
package ssi_pkg;

  localparam int DEF_SET_DEPTH = 32;
  localparam int VAL_W = 31;
  localparam int CMD_W = 2;
  localparam int TDATA_W = 32;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CMD_W-1:0] CMD_INS_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } ssi_state_t;

  typedef struct packed {
    logic ins_a;
    logic ins_b;
    logic start;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic both_avail;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/ssi_store.sv
// sorted cell chain: ordered insert, pop from the head, clear
module ssi_store #(
  parameter int SET_DEPTH = ssi_pkg::DEF_SET_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ins,
  input  logic                     pop,
  input  logic                     clr,
  input  logic [ssi_pkg::VAL_W-1:0] value,
  output logic [ssi_pkg::VAL_W-1:0] head,
  output logic                     nonempty,
  output logic                     full
);
  import ssi_pkg::*;

  localparam int CNT_W = $clog2(SET_DEPTH + 1);

  logic [VAL_W-1:0] cell_r [SET_DEPTH];
  logic [VAL_W-1:0] cell_nxt [SET_DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [SET_DEPTH-1:0] gt;
  logic [SET_DEPTH-1:0] take_prev;

  assign head = cell_r[0];
  assign nonempty = (cnt_r != '0);
  assign full = (cnt_r == CNT_W'(SET_DEPTH));

  always_comb begin
    for (int i = 0; i < SET_DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < cnt_r) && (cell_r[i] > value);
    end
    take_prev[0] = 1'b0;
    for (int i = 1; i < SET_DEPTH; i++) begin
      take_prev[i] = gt[i-1];
    end
  end

  always_comb begin
    cell_nxt = cell_r;
    cnt_nxt = cnt_r;
    if (clr) begin
      cnt_nxt = '0;
    end else if (ins) begin
      if (!full) begin
        cnt_nxt = cnt_r + 1'b1;
        cell_nxt[0] = value;
        if (!(cnt_r == '0 || gt[0])) begin
          cell_nxt[0] = cell_r[0];
        end
        for (int i = 1; i < SET_DEPTH; i++) begin
          if (CNT_W'(i) == cnt_r || gt[i]) begin
            cell_nxt[i] = take_prev[i] ? cell_r[i-1] : value;
          end
        end
      end
    end else if (pop) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int i = 0; i < SET_DEPTH - 1; i++) begin
        cell_nxt[i] = cell_r[i+1];
      end
    end
  end

  // cells hold payload only
  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/ssi_datapath.sv
// datapath: both stores, merge compare, pending result, output register
module ssi_datapath #(
  parameter int SET_DEPTH = ssi_pkg::DEF_SET_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssi_pkg::dp_cmd_t              cmd,
  output ssi_pkg::dp_sts_t              sts,
  input  logic [ssi_pkg::VAL_W-1:0]     in_value,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ssi_pkg::TDATA_W-1:0]   out_tdata,
  output logic                          out_tlast,
  output logic [ssi_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import ssi_pkg::*;

  logic [VAL_W-1:0] head_a;
  logic [VAL_W-1:0] head_b;
  logic ne_a;
  logic ne_b;
  logic full_a;
  logic full_b;
  logic lt;
  logic eq;
  logic pop_a;
  logic pop_b;
  logic new_val;

  logic overflow_r;
  logic pend_valid_r;
  logic [VAL_W-1:0] pend_val_r;
  logic out_valid_r;
  logic [VAL_W-1:0] out_val_r;
  logic out_last_r;
  logic out_empty_r;
  logic out_ovf_r;

  logic push;
  logic [VAL_W-1:0] push_val;
  logic push_last;
  logic push_empty;

  assign lt = head_a < head_b;
  assign eq = head_a == head_b;
  assign pop_a = cmd.step && (lt || eq);
  assign pop_b = cmd.step && !lt;
  assign new_val = cmd.step && eq && (!pend_valid_r || head_a != pend_val_r);

  ssi_store #(.SET_DEPTH(SET_DEPTH)) u_store_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .ins      (cmd.ins_a),
    .pop      (pop_a),
    .clr      (cmd.finish),
    .value    (in_value),
    .head     (head_a),
    .nonempty (ne_a),
    .full     (full_a)
  );

  ssi_store #(.SET_DEPTH(SET_DEPTH)) u_store_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .ins      (cmd.ins_b),
    .pop      (pop_b),
    .clr      (cmd.finish),
    .value    (in_value),
    .head     (head_b),
    .nonempty (ne_b),
    .full     (full_b)
  );

  assign sts.both_avail = ne_a && ne_b;
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    push = 1'b0;
    push_val = pend_val_r;
    push_last = 1'b0;
    push_empty = 1'b0;
    if (new_val && pend_valid_r) begin
      push = 1'b1;
    end else if (cmd.finish) begin
      push = 1'b1;
      push_last = 1'b1;
      if (!pend_valid_r) begin
        push_val = '0;
        push_empty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overflow_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((cmd.ins_a && full_a) || (cmd.ins_b && full_b)) begin
        overflow_r <= 1'b1;
      end
      if (cmd.start || cmd.finish) begin
        pend_valid_r <= 1'b0;
      end else if (new_val) begin
        pend_valid_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_val) begin
      pend_val_r <= head_a;
    end
    if (push) begin
      out_val_r <= push_val;
      out_last_r <= push_last;
      out_empty_r <= push_empty;
      out_ovf_r <= overflow_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(TDATA_W - VAL_W){1'b0}}, out_val_r};
  assign out_tlast = out_last_r;
  assign out_tuser = {out_ovf_r, out_empty_r};

endmodule

// File: rtl/ssi_ctrl.sv
// controller state machine: command decode and merge sequencing
module ssi_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ssi_pkg::CMD_W-1:0]    in_cmd,
  input  ssi_pkg::dp_sts_t             sts,
  output ssi_pkg::dp_cmd_t             cmd
);
  import ssi_pkg::*;

  ssi_state_t state_r;
  ssi_state_t state_nxt;
  logic fire;

  assign fire = in_tvalid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (fire && in_cmd == CMD_COMPUTE) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (!sts.both_avail && sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (fire) begin
          case (in_cmd)
            CMD_INS_A: cmd.ins_a = 1'b1;
            CMD_INS_B: cmd.ins_b = 1'b1;
            CMD_COMPUTE: cmd.start = 1'b1;
            default: cmd = '0;
          endcase
        end
      end
      ST_MERGE: begin
        if (sts.out_free) begin
          cmd.step = sts.both_avail;
          cmd.finish = !sts.both_avail;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/sorted_set_intersection.sv
// top level of the sorted set intersection block
//
//   channel | dir | tdata          | tuser                      | tlast
//   in_     | in  | [30:0] value   | [1:0] command              | -
//   out_    | out | [30:0] common  | [0] empty_res [1] overflow | last
//
// inserts are accepted at one item per cycle while the controller is idle
// a compute item is accepted, then each merge compare pops one or both heads (at most
// count_a + count_b - 1 compares), and a closing step follows; the input waits meanwhile
// merge and closing steps stall while the output register holds an untaken item
// synchronous active-low reset empties both stores and clears the overflow flag
module sorted_set_intersection #(
  parameter int SET_DEPTH = ssi_pkg::DEF_SET_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ssi_pkg::TDATA_W-1:0]     in_tdata,  // value
  input  logic [ssi_pkg::IN_TUSER_W-1:0]  in_tuser,  // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ssi_pkg::TDATA_W-1:0]     out_tdata, // common_value
  output logic                            out_tlast,
  output logic [ssi_pkg::OUT_TUSER_W-1:0] out_tuser  // empty_res, overflow
);
  import ssi_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ssi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser[CMD_W-1:0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssi_datapath #(.SET_DEPTH(SET_DEPTH)) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_tdata[VAL_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
